// ----- sv/scpm_pkg.sv -----
// ----------------------------------------------------------------------------
// scpm_pkg
// Shared codes, defaults and types for the servo channel pulse mapper.
// ----------------------------------------------------------------------------
package scpm_pkg;

    localparam int CHANNELS_DEF = 6;

    localparam int CH_W      = 3;
    localparam int ANG_W     = 14;
    localparam int VAL_W     = 12;
    localparam int TRIM_W    = 11;
    localparam int DIG_STEPS = 12;
    localparam int PROD_W    = 24;
    localparam int NUM_W     = 25;
    localparam int DEN2_W    = 13;

    localparam logic [2:0] ACT_WRITE   = 3'd0;
    localparam logic [2:0] ACT_REL_CH  = 3'd1;
    localparam logic [2:0] ACT_REL_ALL = 3'd2;
    localparam logic [2:0] ACT_ENGAGE  = 3'd3;
    localparam logic [2:0] ACT_SET_CAL = 3'd4;
    localparam logic [2:0] ACT_RESUME  = 3'd5;
    localparam logic [2:0] ACT_READ    = 3'd6;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PULSE   = 2'd1;
    localparam logic [1:0] EV_ALL_OFF = 2'd2;
    localparam logic [1:0] EV_ENABLE  = 2'd3;

    localparam logic [1:0] STS_OK          = 2'd0;
    localparam logic [1:0] STS_INVALID_ARG = 2'd1;
    localparam logic [1:0] STS_RELEASED    = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND   = 2'd3;

    localparam logic [VAL_W-1:0] DEF_MIN_PULSE  = 12'd500;
    localparam logic [VAL_W-1:0] DEF_MAX_PULSE  = 12'd2500;
    localparam logic [VAL_W-1:0] DEF_MIN_ANGLE  = 12'd0;
    localparam logic [VAL_W-1:0] DEF_MAX_ANGLE  = 12'd2880;
    localparam logic [VAL_W-1:0] CAL_LOW_PULSE  = 12'd300;
    localparam logic [VAL_W-1:0] CAL_HIGH_PULSE = 12'd3000;
    localparam logic [VAL_W-1:0] PULSE_MAX      = 12'd4095;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] mcand;
        logic [VAL_W-1:0] mplier;
        logic [VAL_W-1:0] den;
    } arith_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quot;
    } arith_rsp_t;

    typedef struct packed {
        logic [1:0]       ev;
        logic [CH_W-1:0]  pch;
        logic [VAL_W-1:0] pw;
        logic [1:0]       sts;
        logic [VAL_W-1:0] pos;
        logic             known;
    } result_t;

endpackage

// ----- sv/servo_channel_pulse_mapper_unit.sv -----
// ----------------------------------------------------------------------------
// servo_channel_pulse_mapper_unit
// Per-channel servo calibration, angle-to-pulse mapping and position tracking.
// ----------------------------------------------------------------------------
// One command per transfer, one result per command. A write that maps a new
// angle, and a resume whose read-back falls strictly inside the calibrated
// pulse span, run the bit-serial arithmetic unit (shift-add multiply,
// forming the rounded dividend, restoring divide); a final step then
// saturates the pulse or places the resumed angle and loads the output
// register once it is free. Every other command (release, engage, set
// calibration, read, refused or skipped writes, other resumes) returns its
// result in the cycle after the transfer. Only one command is in flight; the
// next is taken once its result sits in the output register. Tables come out
// of reset with their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module servo_channel_pulse_mapper_unit
    import scpm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0]              action,
    input  logic [CH_W-1:0]         channel,
    input  logic signed [ANG_W-1:0] angle,
    input  logic [VAL_W-1:0]        cal_min_pulse,
    input  logic [VAL_W-1:0]        cal_max_pulse,
    input  logic [VAL_W-1:0]        cal_min_angle,
    input  logic [VAL_W-1:0]        cal_max_angle,
    input  logic signed [TRIM_W-1:0] cal_trim,
    input  logic [VAL_W-1:0]        readback_pulse,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              drive_event,
    output logic [CH_W-1:0]         pulse_channel,
    output logic [VAL_W-1:0]        pulse_width,
    output logic [1:0]              status,
    output logic [VAL_W-1:0]        position,
    output logic                    position_known
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    // calibration and position tables
    logic [VAL_W-1:0]         min_p_reg [CHANNELS];
    logic [VAL_W-1:0]         max_p_reg [CHANNELS];
    logic [VAL_W-1:0]         min_a_reg [CHANNELS];
    logic [VAL_W-1:0]         max_a_reg [CHANNELS];
    logic signed [TRIM_W-1:0] trim_reg  [CHANNELS];
    logic [VAL_W-1:0]         last_reg  [CHANNELS];
    logic [CHANNELS-1:0]      known_reg;
    logic                     latch_reg;

    logic [1:0]  state_reg, state_next;
    logic        out_valid_reg;
    result_t     out_reg;

    // command held while the arithmetic runs
    logic [2:0]              act_reg;
    logic [CH_W-1:0]         chan_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic signed [ANG_W-1:0] base_reg;
    logic [VAL_W-1:0]        amin_reg;
    logic [VAL_W-1:0]        amax_reg;

    arith_req_t arith_req;
    arith_rsp_t arith_rsp;

    logic                    acc;
    logic                    slot_free;
    logic                    fin_load;
    logic                    ch_ok;
    logic [IDX_W-1:0]        idx;
    logic [VAL_W-1:0]        cur_minp, cur_maxp, cur_amin, cur_amax, cur_last;
    logic signed [TRIM_W-1:0] cur_trim;
    logic                    cur_known;
    logic signed [ANG_W-1:0] trim_ext;
    logic signed [ANG_W-1:0] amin_s, amax_s;
    logic [VAL_W-1:0]        a_cl;
    logic                    repeat_hit;
    logic [VAL_W-1:0]        pdiff, span, a_off;
    logic signed [ANG_W-1:0] base_w;
    logic signed [ANG_W-1:0] rs_off;
    logic                    off_pos, off_sat;

    result_t          res_d;
    logic             start_d;
    logic [VAL_W-1:0] mcand_d, mpl_d, den_d;
    logic             set_last, clr_known, wr_cal, rel_all, engage;
    logic [VAL_W-1:0] last_val_d;

    logic signed [ANG_W:0] us_w;
    logic [VAL_W-1:0]      us_sat;
    logic [VAL_W:0]        ang_w;
    logic [VAL_W-1:0]      fin_ang;
    result_t               fin_res;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign acc       = in_valid && in_ready;
    assign fin_load  = (state_reg == S_FIN) && slot_free;

    assign ch_ok = ({1'b0, channel} < (CH_W + 1)'(CHANNELS));
    assign idx   = ch_ok ? channel[IDX_W-1:0] : '0;

    assign cur_minp  = min_p_reg[idx];
    assign cur_maxp  = max_p_reg[idx];
    assign cur_amin  = min_a_reg[idx];
    assign cur_amax  = max_a_reg[idx];
    assign cur_trim  = trim_reg[idx];
    assign cur_last  = last_reg[idx];
    assign cur_known = known_reg[idx];

    assign trim_ext = {{(ANG_W - TRIM_W){cur_trim[TRIM_W-1]}}, cur_trim};
    assign amin_s   = {2'b00, cur_amin};
    assign amax_s   = {2'b00, cur_amax};

    always_comb
    begin
        if (angle < amin_s)
        begin
            a_cl = cur_amin;
        end
        else if (angle > amax_s)
        begin
            a_cl = cur_amax;
        end
        else
        begin
            a_cl = angle[VAL_W-1:0];
        end
    end

    assign repeat_hit = cur_known && (a_cl == cur_last);
    assign pdiff      = cur_maxp - cur_minp;
    assign span       = cur_amax - cur_amin;
    assign a_off      = a_cl - cur_amin;
    assign base_w     = $signed({2'b00, cur_minp}) + trim_ext;
    assign rs_off     = $signed({2'b00, readback_pulse}) - trim_ext
                      - $signed({2'b00, cur_minp});
    assign off_pos    = (rs_off > 14'sd0);
    // at or past the top of the pulse span the angle pins to the maximum
    assign off_sat    = (rs_off >= $signed({2'b00, pdiff}));

    always_comb
    begin
        res_d      = '0;
        start_d    = 1'b0;
        mcand_d    = '0;
        mpl_d      = '0;
        den_d      = '0;
        set_last   = 1'b0;
        last_val_d = '0;
        clr_known  = 1'b0;
        wr_cal     = 1'b0;
        rel_all    = 1'b0;
        engage     = 1'b0;
        unique case (action)
            ACT_WRITE:
            begin
                if (!ch_ok)
                begin
                    res_d.sts = STS_INVALID_ARG;
                end
                else if (latch_reg)
                begin
                    res_d.sts = STS_RELEASED;
                end
                else if (!repeat_hit)
                begin
                    start_d    = 1'b1;
                    set_last   = 1'b1;
                    last_val_d = a_cl;
                    mcand_d    = pdiff;
                    mpl_d      = a_off;
                    den_d      = span;
                end
            end
            ACT_REL_CH:
            begin
                if (!ch_ok)
                begin
                    res_d.sts = STS_INVALID_ARG;
                end
                else if (!latch_reg)
                begin
                    clr_known = 1'b1;
                    res_d.ev  = EV_PULSE;
                    res_d.pch = channel;
                end
            end
            ACT_REL_ALL:
            begin
                rel_all  = 1'b1;
                res_d.ev = EV_ALL_OFF;
            end
            ACT_ENGAGE:
            begin
                if (latch_reg)
                begin
                    engage   = 1'b1;
                    res_d.ev = EV_ENABLE;
                end
            end
            ACT_SET_CAL:
            begin
                if (!ch_ok || (cal_min_pulse < CAL_LOW_PULSE)
                    || (cal_max_pulse > CAL_HIGH_PULSE)
                    || (cal_min_pulse >= cal_max_pulse)
                    || (cal_max_angle <= cal_min_angle))
                begin
                    res_d.sts = STS_INVALID_ARG;
                end
                else
                begin
                    wr_cal = 1'b1;
                end
            end
            ACT_RESUME:
            begin
                if (!ch_ok)
                begin
                    res_d.sts = STS_INVALID_ARG;
                end
                else if (readback_pulse == '0)
                begin
                    clr_known = 1'b1;
                    res_d.sts = STS_NOT_FOUND;
                end
                else if (!off_pos)
                begin
                    set_last   = 1'b1;
                    last_val_d = cur_amin;
                end
                else if (off_sat)
                begin
                    set_last   = 1'b1;
                    last_val_d = cur_amax;
                end
                else
                begin
                    start_d = 1'b1;
                    mcand_d = rs_off[VAL_W-1:0];
                    mpl_d   = span;
                    den_d   = pdiff;
                end
            end
            ACT_READ:
            begin
                if (!ch_ok)
                begin
                    res_d.sts = STS_INVALID_ARG;
                end
                else
                begin
                    res_d.known = cur_known;
                    res_d.pos   = cur_known ? cur_last : '0;
                end
            end
            default:
            begin
                res_d.sts = STS_INVALID_ARG;
            end
        endcase
    end

    assign arith_req.start  = acc && start_d;
    assign arith_req.mcand  = mcand_d;
    assign arith_req.mplier = mpl_d;
    assign arith_req.den    = den_d;

    scpm_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (arith_req),
        .rsp   (arith_rsp)
    );

    // finish: saturate the pulse, or place the resumed angle inside the span
    assign us_w  = {base_reg[ANG_W-1], base_reg} + $signed({3'b000, arith_rsp.quot});
    assign ang_w = {1'b0, amin_reg} + {1'b0, arith_rsp.quot};

    always_comb
    begin
        if (us_w < 15'sd0)
        begin
            us_sat = '0;
        end
        else if (us_w > $signed({3'b000, PULSE_MAX}))
        begin
            us_sat = PULSE_MAX;
        end
        else
        begin
            us_sat = us_w[VAL_W-1:0];
        end
        fin_ang = (ang_w > {1'b0, amax_reg}) ? amax_reg : ang_w[VAL_W-1:0];
        fin_res = '0;
        if (act_reg == ACT_WRITE)
        begin
            fin_res.ev  = EV_PULSE;
            fin_res.pch = chan_reg;
            fin_res.pw  = us_sat;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc && start_d)
                begin
                    state_next = S_BUSY;
                end
            end
            S_BUSY:
            begin
                if (arith_rsp.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((acc && !start_d) || fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && !start_d)
        begin
            out_reg <= res_d;
        end
        else if (fin_load)
        begin
            out_reg <= fin_res;
        end
        if (acc)
        begin
            act_reg  <= action;
            chan_reg <= channel;
            idx_reg  <= idx;
            base_reg <= base_w;
            amin_reg <= cur_amin;
            amax_reg <= cur_amax;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                min_p_reg[i] <= DEF_MIN_PULSE;
                max_p_reg[i] <= DEF_MAX_PULSE;
                min_a_reg[i] <= DEF_MIN_ANGLE;
                max_a_reg[i] <= DEF_MAX_ANGLE;
                trim_reg[i]  <= '0;
                last_reg[i]  <= '0;
            end
            known_reg <= '0;
            latch_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                if (wr_cal)
                begin
                    min_p_reg[idx] <= cal_min_pulse;
                    max_p_reg[idx] <= cal_max_pulse;
                    min_a_reg[idx] <= cal_min_angle;
                    max_a_reg[idx] <= cal_max_angle;
                    trim_reg[idx]  <= cal_trim;
                    known_reg[idx] <= 1'b0;
                end
                if (set_last)
                begin
                    last_reg[idx]  <= last_val_d;
                    known_reg[idx] <= 1'b1;
                end
                if (clr_known)
                begin
                    known_reg[idx] <= 1'b0;
                end
                if (rel_all)
                begin
                    known_reg <= '0;
                    latch_reg <= 1'b1;
                end
                if (engage)
                begin
                    latch_reg <= 1'b0;
                end
            end
            else if (fin_load && act_reg == ACT_RESUME)
            begin
                last_reg[idx_reg]  <= fin_ang;
                known_reg[idx_reg] <= 1'b1;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign drive_event    = out_reg.ev;
    assign pulse_channel  = out_reg.pch;
    assign pulse_width    = out_reg.pw;
    assign status         = out_reg.sts;
    assign position       = out_reg.pos;
    assign position_known = out_reg.known;

    a_released_write: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && action == ACT_WRITE && ch_ok && latch_reg)
        |=> (out_valid_reg && out_reg.sts == STS_RELEASED && out_reg.ev == EV_NONE))
        else $error("write while released not refused");

    a_release_all: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && action == ACT_REL_ALL) |=> (known_reg == '0 && latch_reg))
        else $error("release all left a known flag or open latch");

    a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
        fin_load |=> (out_valid_reg && out_reg.sts == STS_OK
                      && (out_reg.ev == EV_PULSE || out_reg.ev == EV_NONE)))
        else $error("arithmetic result not loaded");

endmodule

// ----- sv/scpm_arith.sv -----
// ----------------------------------------------------------------------------
// scpm_arith
// Bit-serial rounded ratio: quot = floor((2*mcand*mplier + den) / (2*den)).
// Shift-add multiply MSB first, then restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module scpm_arith
    import scpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  arith_req_t req,
    output arith_rsp_t rsp
);

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_MUL  = 2'd1;
    localparam logic [1:0] A_PREP = 2'd2;
    localparam logic [1:0] A_DIV  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [VAL_W-1:0]  mcand_reg, mcand_next;
    logic [VAL_W-1:0]  mpl_reg, mpl_next;
    logic [VAL_W-1:0]  den_reg, den_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [DEN2_W-1:0] rem_reg, rem_next;
    logic [VAL_W-1:0]  low_reg, low_next;
    logic [VAL_W-1:0]  quot_reg, quot_next;

    logic [NUM_W-1:0]  num2;
    logic [DEN2_W-1:0] den2;
    logic [DEN2_W:0]   trial;
    logic [DEN2_W:0]   diff;
    logic              take;
    logic              last_step;

    assign num2      = {acc_reg, 1'b0} + NUM_W'(den_reg);
    assign den2      = {den_reg, 1'b0};
    assign trial     = {rem_reg, low_reg[VAL_W-1]};
    assign diff      = trial - {1'b0, den2};
    assign take      = (trial >= {1'b0, den2});
    assign last_step = (cnt_reg == 4'(DIG_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        mcand_next = mcand_reg;
        mpl_next   = mpl_reg;
        den_next   = den_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        quot_next  = quot_reg;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    mcand_next = req.mcand;
                    mpl_next   = req.mplier;
                    den_next   = req.den;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = A_MUL;
                end
            end
            A_MUL:
            begin
                // shift-add, multiplier MSB first
                acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                         + PROD_W'(mpl_reg[VAL_W-1] ? mcand_reg : '0);
                mpl_next = {mpl_reg[VAL_W-2:0], 1'b0};
                cnt_next = cnt_reg + 4'd1;
                if (last_step)
                begin
                    state_next = A_PREP;
                end
            end
            A_PREP:
            begin
                // top bits already below the divisor since the quotient fits 12 bits
                rem_next   = num2[NUM_W-1:VAL_W];
                low_next   = num2[VAL_W-1:0];
                quot_next  = '0;
                cnt_next   = '0;
                state_next = A_DIV;
            end
            A_DIV:
            begin
                rem_next  = take ? diff[DEN2_W-1:0] : trial[DEN2_W-1:0];
                low_next  = {low_reg[VAL_W-2:0], 1'b0};
                quot_next = {quot_reg[VAL_W-2:0], take};
                cnt_next  = cnt_reg + 4'd1;
                if (last_step)
                begin
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        mpl_reg   <= mpl_next;
        den_reg   <= den_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        low_reg   <= low_next;
        quot_reg  <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == A_DIV) |-> (rem_reg < den2))
        else $error("partial remainder reached divisor");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> (state_reg == A_IDLE))
        else $error("start while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> (!rsp.done && state_reg == A_IDLE))
        else $error("done not a single pulse");

endmodule

// ----- test/tb_servo_channel_pulse_mapper_unit.sv -----
// ----------------------------------------------------------------------------
// tb_servo_channel_pulse_mapper_unit
// Self-checking bench for the servo channel pulse mapper. A driver pulls
// commands from a pending queue and offers them on the input channel, and each
// transfer is run through a cycle-free model of the calibration tables,
// position tracking and release latch. A monitor checks every result field
// against the oldest predicted result. Directed commands cover the corner
// cases, and constrained-by-hand random commands cover the rest, with random
// stalls on both sides.
// ----------------------------------------------------------------------------
module tb_servo_channel_pulse_mapper_unit
    import scpm_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH        = CHANNELS_DEF;
    localparam int RAND_CMDS  = 1100;
    localparam int TAIL_CMDS  = 150;
    localparam int CYCLE_CAP  = 400000;
    localparam int LONG_HOLD  = 400;
    localparam int HOLD_AFTER = 60;

    typedef struct {
        logic [2:0]              act;
        logic [CH_W-1:0]         chan;
        logic signed [ANG_W-1:0] ang;
        logic [VAL_W-1:0]        min_p;
        logic [VAL_W-1:0]        max_p;
        logic [VAL_W-1:0]        min_a;
        logic [VAL_W-1:0]        max_a;
        logic signed [TRIM_W-1:0] trim;
        logic [VAL_W-1:0]        rb;
    } servo_cmd_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [2:0]               action = ACT_READ;
    logic [CH_W-1:0]          channel = '0;
    logic signed [ANG_W-1:0]  angle = '0;
    logic [VAL_W-1:0]         cal_min_pulse = '0;
    logic [VAL_W-1:0]         cal_max_pulse = '0;
    logic [VAL_W-1:0]         cal_min_angle = '0;
    logic [VAL_W-1:0]         cal_max_angle = '0;
    logic signed [TRIM_W-1:0] cal_trim = '0;
    logic [VAL_W-1:0]         readback_pulse = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [1:0]               drive_event;
    logic [CH_W-1:0]          pulse_channel;
    logic [VAL_W-1:0]         pulse_width;
    logic [1:0]               status;
    logic [VAL_W-1:0]         position;
    logic                     position_known;

    // model of the block state
    logic [VAL_W-1:0]         cal_min_p [NCH];
    logic [VAL_W-1:0]         cal_max_p [NCH];
    logic [VAL_W-1:0]         cal_min_a [NCH];
    logic [VAL_W-1:0]         cal_max_a [NCH];
    logic signed [TRIM_W-1:0] cal_trim_t [NCH];
    logic [VAL_W-1:0]         last_ang [NCH];
    logic                     ang_known [NCH];
    logic                     released;

    servo_cmd_t cmds_pending[$];
    servo_cmd_t cur_cmd;
    result_t    drive_results_due[$];
    result_t    due_res;

    int src_gap = 0;
    int sink_gap = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit stim_loaded = 1'b0;
    int results_seen = 0;
    int errors = 0;
    int cycles = 0;
    int gen_last_ang [8];

    servo_channel_pulse_mapper_unit #(.CHANNELS(NCH)) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .channel        (channel),
        .angle          (angle),
        .cal_min_pulse  (cal_min_pulse),
        .cal_max_pulse  (cal_max_pulse),
        .cal_min_angle  (cal_min_angle),
        .cal_max_angle  (cal_max_angle),
        .cal_trim       (cal_trim),
        .readback_pulse (readback_pulse),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive_event    (drive_event),
        .pulse_channel  (pulse_channel),
        .pulse_width    (pulse_width),
        .status         (status),
        .position       (position),
        .position_known (position_known)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void reset_servo_state();
        for (int i = 0; i < NCH; i++)
        begin
            cal_min_p[i]  = DEF_MIN_PULSE;
            cal_max_p[i]  = DEF_MAX_PULSE;
            cal_min_a[i]  = DEF_MIN_ANGLE;
            cal_max_a[i]  = DEF_MAX_ANGLE;
            cal_trim_t[i] = '0;
            last_ang[i]   = '0;
            ang_known[i]  = 1'b0;
        end
        released = 1'b0;
    endfunction

    // floor(n/d + 1/2) for n >= 0, d > 0
    function automatic longint div_round(longint n, longint d);
        return (2 * n + d) / (2 * d);
    endfunction

    function automatic result_t compute_drive_result(servo_cmd_t c);
        result_t r;
        bit      ok;
        int      ch;
        longint  amin, amax, pmin, pmax, trim_v, a, us, n, prev;
        r    = '0;
        ok   = c.chan < NCH;
        ch   = ok ? int'(c.chan) : 0;
        amin = cal_min_a[ch];
        amax = cal_max_a[ch];
        pmin = cal_min_p[ch];
        pmax = cal_max_p[ch];
        trim_v = cal_trim_t[ch];
        prev = last_ang[ch];
        case (c.act)
            ACT_WRITE:
            begin
                if (!ok)
                    r.sts = STS_INVALID_ARG;
                else if (released)
                    r.sts = STS_RELEASED;
                else
                begin
                    a = c.ang;
                    if (a < amin)
                        a = amin;
                    else if (a > amax)
                        a = amax;
                    // skip a repeat of the known angle
                    if (!(ang_known[ch] && a == prev))
                    begin
                        last_ang[ch]  = a[VAL_W-1:0];
                        ang_known[ch] = 1'b1;
                        us = pmin + trim_v + div_round((pmax - pmin) * (a - amin), amax - amin);
                        if (us < 0)
                            us = 0;
                        if (us > PULSE_MAX)
                            us = PULSE_MAX;
                        r.ev  = EV_PULSE;
                        r.pch = CH_W'(ch);
                        r.pw  = us[VAL_W-1:0];
                    end
                end
            end
            ACT_REL_CH:
            begin
                if (!ok)
                    r.sts = STS_INVALID_ARG;
                else if (!released)
                begin
                    ang_known[ch] = 1'b0;
                    r.ev  = EV_PULSE;
                    r.pch = CH_W'(ch);
                end
            end
            ACT_REL_ALL:
            begin
                released = 1'b1;
                for (int i = 0; i < NCH; i++)
                    ang_known[i] = 1'b0;
                r.ev = EV_ALL_OFF;
            end
            ACT_ENGAGE:
            begin
                if (released)
                begin
                    released = 1'b0;
                    r.ev = EV_ENABLE;
                end
            end
            ACT_SET_CAL:
            begin
                if (!ok || c.min_p < CAL_LOW_PULSE || c.max_p > CAL_HIGH_PULSE ||
                    c.min_p >= c.max_p || c.max_a <= c.min_a)
                    r.sts = STS_INVALID_ARG;
                else
                begin
                    cal_min_p[ch]  = c.min_p;
                    cal_max_p[ch]  = c.max_p;
                    cal_min_a[ch]  = c.min_a;
                    cal_max_a[ch]  = c.max_a;
                    cal_trim_t[ch] = c.trim;
                    ang_known[ch]  = 1'b0;
                end
            end
            ACT_RESUME:
            begin
                if (!ok)
                    r.sts = STS_INVALID_ARG;
                else if (c.rb == '0)
                begin
                    ang_known[ch] = 1'b0;
                    r.sts = STS_NOT_FOUND;
                end
                else
                begin
                    // inverse map; offsets at or below the span floor land on amin
                    n = (longint'(c.rb) - trim_v - pmin) * (amax - amin);
                    a = amin;
                    if (n > 0)
                        a = amin + div_round(n, pmax - pmin);
                    if (a > amax)
                        a = amax;
                    last_ang[ch]  = a[VAL_W-1:0];
                    ang_known[ch] = 1'b1;
                end
            end
            ACT_READ:
            begin
                if (!ok)
                    r.sts = STS_INVALID_ARG;
                else
                begin
                    r.known = ang_known[ch];
                    r.pos   = ang_known[ch] ? last_ang[ch] : '0;
                end
            end
            default:
                r.sts = STS_INVALID_ARG;
        endcase
        return r;
    endfunction

    // command with random calibration fields, which these actions ignore
    function automatic servo_cmd_t make_cmd(logic [2:0] act, int chan, int ang, int rb);
        servo_cmd_t c;
        c.act   = act;
        c.chan  = CH_W'(chan);
        c.ang   = ANG_W'(ang);
        c.min_p = VAL_W'($urandom);
        c.max_p = VAL_W'($urandom);
        c.min_a = VAL_W'($urandom);
        c.max_a = VAL_W'($urandom);
        c.trim  = TRIM_W'($urandom);
        c.rb    = VAL_W'(rb);
        return c;
    endfunction

    function automatic servo_cmd_t make_cal(int chan, int minp, int maxp, int mina, int maxa,
                                            int trim);
        servo_cmd_t c;
        c       = make_cmd(ACT_SET_CAL, chan, $urandom, $urandom);
        c.min_p = VAL_W'(minp);
        c.max_p = VAL_W'(maxp);
        c.min_a = VAL_W'(mina);
        c.max_a = VAL_W'(maxa);
        c.trim  = TRIM_W'(trim);
        return c;
    endfunction

    function automatic servo_cmd_t random_command();
        servo_cmd_t c;
        int         pick, sel, minp, mina;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 9);
        c = make_cmd(ACT_READ, 0, $urandom, $urandom);
        c.chan = (sel == 0) ? CH_W'($urandom_range(NCH, 7)) : CH_W'($urandom_range(0, NCH - 1));
        if (pick < 40)
        begin
            c.act = ACT_WRITE;
            sel = $urandom_range(0, 9);
            if (sel < 2)
                c.ang = ANG_W'(gen_last_ang[c.chan]);
            else if (sel < 8)
                c.ang = ANG_W'($urandom_range(0, 4095));
            gen_last_ang[c.chan] = c.ang;
        end
        else if (pick < 52)
            c.act = ACT_READ;
        else if (pick < 64)
        begin
            c.act = ACT_RESUME;
            sel = $urandom_range(0, 9);
            if (sel == 0)
                c.rb = '0;
            else if (sel < 7)
                c.rb = VAL_W'($urandom_range(300, 3000));
        end
        else if (pick < 74)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                minp = $urandom_range(300, 2999);
                mina = $urandom_range(0, 2000);
                c = make_cal(c.chan, minp, $urandom_range(minp + 1, 3000), mina,
                             $urandom_range(mina + 1, ($urandom_range(0, 3) == 0) ?
                                            mina + 8 : 4095), $urandom);
            end
            c.act = ACT_SET_CAL;
        end
        else if (pick < 82)
            c.act = ACT_REL_CH;
        else if (pick < 85)
            c.act = ACT_REL_ALL;
        else if (pick < 96)
            c.act = ACT_ENGAGE;
        else
            c.act = 3'($urandom);
        return c;
    endfunction

    function automatic bit no_idling();
        return stim_loaded && cmds_pending.size() <= TAIL_CMDS;
    endfunction

    function automatic void check_field(string name, logic [VAL_W-1:0] exp_v,
                                        logic [VAL_W-1:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
            errors++;
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            src_gap  <= 0;
            reset_servo_state();
        end
        else
        begin
            if (in_valid && in_ready)
                drive_results_due.push_back(compute_drive_result(cur_cmd));
            if (in_valid && !in_ready)
            begin
                // hold the offered command
            end
            else if (src_gap > 0)
            begin
                src_gap  <= src_gap - 1;
                in_valid <= 1'b0;
            end
            else if (cmds_pending.size() == 0)
                in_valid <= 1'b0;
            else if (!no_idling() && $urandom_range(0, 7) == 0)
            begin
                src_gap  <= $urandom_range(0, 15);
                in_valid <= 1'b0;
            end
            else
            begin
                cur_cmd = cmds_pending.pop_front();
                action         <= cur_cmd.act;
                channel        <= cur_cmd.chan;
                angle          <= cur_cmd.ang;
                cal_min_pulse  <= cur_cmd.min_p;
                cal_max_pulse  <= cur_cmd.max_p;
                cal_min_angle  <= cur_cmd.min_a;
                cal_max_angle  <= cur_cmd.max_a;
                cal_trim       <= cur_cmd.trim;
                readback_pulse <= cur_cmd.rb;
                in_valid       <= 1'b1;
            end
        end
    end

    // result side back-pressure, with one long hold-off to fill the block
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_gap  <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!hold_done && results_seen == HOLD_AFTER)
        begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap  <= sink_gap - 1;
            out_ready <= 1'b0;
        end
        else if (!no_idling() && $urandom_range(0, 7) == 0)
        begin
            sink_gap  <= $urandom_range(0, 15);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (drive_results_due.size() == 0)
            begin
                $display("%0t ns: result transfer with nothing expected", $time);
                errors++;
            end
            else
            begin
                due_res = drive_results_due.pop_front();
                check_field("drive_event", VAL_W'(due_res.ev), VAL_W'(drive_event));
                check_field("pulse_channel", VAL_W'(due_res.pch), VAL_W'(pulse_channel));
                check_field("pulse_width", due_res.pw, pulse_width);
                check_field("status", VAL_W'(due_res.sts), VAL_W'(status));
                check_field("position", due_res.pos, position);
                check_field("position_known", VAL_W'(due_res.known), VAL_W'(position_known));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_CAP)
        begin
            $display("%0t ns: timeout", $time);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < 8; i++)
            gen_last_ang[i] = 0;

        // directed corners
        cmds_pending.push_back(make_cmd(ACT_READ, 0, 0, 0));
        cmds_pending.push_back(make_cmd(ACT_WRITE, 0, 0, 0));
        cmds_pending.push_back(make_cmd(ACT_WRITE, 0, 0, 0));
        cmds_pending.push_back(make_cmd(ACT_WRITE, 0, 2880, 0));
        cmds_pending.push_back(make_cmd(ACT_WRITE, 0, 8191, 0));
        cmds_pending.push_back(make_cmd(ACT_WRITE, 0, -8192, 0));
        cmds_pending.push_back(make_cmd(ACT_WRITE, 1, 1440, 0));
        cmds_pending.push_back(make_cmd(ACT_READ, 1, 0, 0));
        cmds_pending.push_back(make_cmd(ACT_WRITE, 6, 100, 0));
        cmds_pending.push_back(make_cmd(ACT_READ, 7, 0, 0));
        cmds_pending.push_back(make_cal(2, 300, 3000, 0, 4095, -1024));
        cmds_pending.push_back(make_cmd(ACT_WRITE, 2, 0, 0));
        cmds_pending.push_back(make_cal(5, 2999, 3000, 4094, 4095, 1023));
        cmds_pending.push_back(make_cmd(ACT_WRITE, 5, 4095, 0));
        cmds_pending.push_back(make_cal(3, 299, 2500, 0, 2880, 0));
        cmds_pending.push_back(make_cal(3, 500, 3001, 0, 2880, 0));
        cmds_pending.push_back(make_cal(3, 2500, 2500, 0, 2880, 0));
        cmds_pending.push_back(make_cal(3, 500, 2500, 2880, 2880, 0));
        cmds_pending.push_back(make_cal(6, 500, 2500, 0, 2880, 0));
        cmds_pending.push_back(make_cmd(ACT_RESUME, 3, 0, 0));
        cmds_pending.push_back(make_cmd(ACT_RESUME, 3, 0, 100));
        cmds_pending.push_back(make_cmd(ACT_RESUME, 3, 0, 4095));
        cmds_pending.push_back(make_cmd(ACT_RESUME, 3, 0, 1501));
        cmds_pending.push_back(make_cmd(ACT_READ, 3, 0, 0));
        cmds_pending.push_back(make_cmd(ACT_REL_CH, 1, 0, 0));
        cmds_pending.push_back(make_cmd(ACT_REL_ALL, 0, 0, 0));
        cmds_pending.push_back(make_cmd(ACT_WRITE, 0, 1000, 0));
        cmds_pending.push_back(make_cmd(ACT_REL_CH, 2, 0, 0));
        cmds_pending.push_back(make_cal(4, 1000, 2000, 100, 1700, 37));
        cmds_pending.push_back(make_cmd(ACT_RESUME, 4, 0, 1337));
        cmds_pending.push_back(make_cmd(ACT_ENGAGE, 0, 0, 0));
        cmds_pending.push_back(make_cmd(ACT_ENGAGE, 0, 0, 0));
        cmds_pending.push_back(make_cmd(3'd7, 0, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // let the directed part drain completely before going on
        while (cmds_pending.size() != 0 || in_valid || drive_results_due.size() != 0)
            @(posedge clk);

        for (int i = 0; i < RAND_CMDS; i++)
            cmds_pending.push_back(random_command());
        stim_loaded = 1'b1;

        while (cmds_pending.size() != 0 || in_valid || drive_results_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (errors == 0 && drive_results_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/scpm_pkg.sv
sv/scpm_arith.sv
sv/servo_channel_pulse_mapper_unit.sv
test/tb_servo_channel_pulse_mapper_unit.sv
